// ----- design/dba_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dba_pkg: shared types and constants of the decimal BCD arithmetic unit
// Operation, order and status codes, datapath commands, controller states.
// ----------------------------------------------------------------------------
package dba_pkg;

    localparam int LOW_W  = 64;           // 16 BCD digits
    localparam int UP_W   = 56;           // 14 BCD digits
    localparam int RAW_W  = LOW_W + UP_W; // 30 carried digits
    localparam int RAW_DIGITS = RAW_W / 4;

    localparam logic [2:0] OP_ADD = 3'd0;
    localparam logic [2:0] OP_SUB = 3'd1;
    localparam logic [2:0] OP_MUL = 3'd2;
    localparam logic [2:0] OP_DIV = 3'd3;

    localparam logic [1:0] ORD_EQ   = 2'd0;
    localparam logic [1:0] ORD_LESS = 2'd1;
    localparam logic [1:0] ORD_GT   = 2'd2;

    localparam logic [1:0] ST_OK   = 2'd0;
    localparam logic [1:0] ST_LOST = 2'd1;
    localparam logic [1:0] ST_NEG  = 2'd2;
    localparam logic [1:0] ST_DIVZ = 2'd3;

    typedef enum logic [3:0] {
        CMD_NONE,
        CMD_LOAD,
        CMD_ADD,
        CMD_SUB,
        CMD_MUL_BUILD,
        CMD_MUL_CLR,
        CMD_MUL_ROW,
        CMD_MUL_DONE,
        CMD_DIV_ZERO,
        CMD_DIV_SHIFT,
        CMD_DIV_TRY
    } t_cmd;

    typedef struct packed {
        t_cmd       op;
        logic [3:0] idx;
    } t_dp_cmd;

    typedef struct packed {
        logic b_zero;
        logic div_more;
    } t_dp_stat;

    typedef enum logic [3:0] {
        S_IDLE,
        S_ADD,
        S_SUB,
        S_MBUILD,
        S_MCLR,
        S_MROW,
        S_MDONE,
        S_DCHK,
        S_DSHIFT,
        S_DTRY,
        S_DONE
    } t_state;

    // Read a nibble above 9 as the digit 9.
    function automatic logic [3:0] clamp_digit(input logic [3:0] nib);
        clamp_digit = (nib > 4'd9) ? 4'd9 : nib;
    endfunction

endpackage

// ----- design/dba_bcd_adder.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dba_bcd_adder: packed-BCD adder and subtractor
// One binary add with +6 digit bias, then per-digit correction; subtract
// adds the nines complement with carry in, carry out then means x >= y.
// ----------------------------------------------------------------------------
module dba_bcd_adder #(
    parameter int N = 31
) (
    input  logic [4*N-1:0] i_x,
    input  logic [4*N-1:0] i_y,
    input  logic           i_sub,
    output logic [4*N-1:0] o_sum,
    output logic           o_cout
);

    logic [4*N-1:0] ye6;
    logic [4*N:0]   t;
    logic [4*N:0]   cv;

    always_comb begin
        for (int k = 0; k < N; k++) begin
            ye6[4*k +: 4] = (i_sub ? (4'd9 - i_y[4*k +: 4]) : i_y[4*k +: 4]) + 4'd6;
        end
        t  = {1'b0, i_x} + {1'b0, ye6} + (4*N+1)'(i_sub);
        // carry into each bit position
        cv = {1'b0, i_x} ^ {1'b0, ye6} ^ t;
        for (int k = 0; k < N; k++) begin
            o_sum[4*k +: 4] = cv[4*(k+1)] ? t[4*k +: 4] : (t[4*k +: 4] + 4'd10);
        end
        o_cout = cv[4*N];
    end

endmodule

// ----- design/dba_datapath.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dba_datapath: operand, accumulator and result registers
// Shares one BCD adder across add, subtract, multiple build, product rows
// and trial subtraction of the long division.
// ----------------------------------------------------------------------------
module dba_datapath import dba_pkg::*; #(
    parameter int DIGITS = 30
) (
    input  logic              i_clk,
    input  t_dp_cmd           i_cmd,
    input  logic [UP_W-1:0]   i_a_upper,
    input  logic [LOW_W-1:0]  i_a_lower,
    input  logic [UP_W-1:0]   i_b_upper,
    input  logic [LOW_W-1:0]  i_b_lower,
    output t_dp_stat          o_stat,
    output logic [UP_W-1:0]   o_result_upper,
    output logic [LOW_W-1:0]  o_result_lower,
    output logic [1:0]        o_order,
    output logic [1:0]        o_status
);

    localparam int DW   = 4 * DIGITS;
    localparam int NW   = DW + 4;
    localparam int MAXD = (DIGITS > RAW_DIGITS) ? DIGITS : RAW_DIGITS;
    localparam int VW   = 4 * MAXD;

    logic [VW-1:0] a_ext, b_ext, res_vec;
    logic [DW-1:0] a_dig, b_dig;
    logic [1:0]    ld_order;

    logic [DW-1:0] r_a, n_a, r_b, n_b, r_l, n_l;
    logic [NW-1:0] r_h, n_h;
    logic [3:0]    r_q, n_q;
    logic [1:0]    r_order, n_order, r_status, n_status;
    logic [NW-1:0] r_mul [10];

    logic [NW-1:0] add_x, add_y, sum, mul_sel;
    logic          add_sub, cout;

    assign a_ext = VW'({i_a_upper, i_a_lower});
    assign b_ext = VW'({i_b_upper, i_b_lower});

    always_comb begin
        for (int k = 0; k < DIGITS; k++) begin
            a_dig[4*k +: 4] = clamp_digit(a_ext[4*k +: 4]);
            b_dig[4*k +: 4] = clamp_digit(b_ext[4*k +: 4]);
        end
    end

    assign ld_order = (a_dig == b_dig) ? ORD_EQ : ((a_dig < b_dig) ? ORD_LESS : ORD_GT);
    assign mul_sel  = (r_b[3:0] == 4'd0) ? '0 : r_mul[r_b[3:0]];

    dba_bcd_adder #(.N(DIGITS + 1)) u_add (
        .i_x    (add_x),
        .i_y    (add_y),
        .i_sub  (add_sub),
        .o_sum  (sum),
        .o_cout (cout)
    );

    always_comb begin
        add_x   = r_h;
        add_y   = {4'd0, r_b};
        add_sub = 1'b1;
        case (i_cmd.op)
            CMD_ADD: begin
                add_x   = {4'd0, r_a};
                add_sub = 1'b0;
            end
            CMD_SUB: begin
                add_x = {4'd0, r_a};
            end
            CMD_MUL_BUILD: begin
                add_y   = {4'd0, r_a};
                add_sub = 1'b0;
            end
            CMD_MUL_ROW: begin
                add_y   = mul_sel;
                add_sub = 1'b0;
            end
            default: ;
        endcase
    end

    assign o_stat.b_zero   = (r_b == '0);
    assign o_stat.div_more = cout && (r_q != 4'd9);

    always_comb begin
        n_a      = r_a;
        n_b      = r_b;
        n_h      = r_h;
        n_l      = r_l;
        n_q      = r_q;
        n_order  = r_order;
        n_status = r_status;
        unique case (i_cmd.op)
            CMD_LOAD: begin
                n_a      = a_dig;
                n_b      = b_dig;
                n_h      = '0;
                n_l      = '0;
                n_order  = ld_order;
                n_status = ST_OK;
            end
            CMD_ADD: begin
                n_l      = sum[DW-1:0];
                n_status = (sum[NW-1:DW] != 4'd0) ? ST_LOST : ST_OK;
            end
            CMD_SUB: begin
                if (r_order == ORD_LESS) begin
                    n_status = ST_NEG;
                end else begin
                    n_l = sum[DW-1:0];
                end
            end
            CMD_MUL_BUILD: n_h = sum;
            CMD_MUL_CLR:   n_h = '0;
            CMD_MUL_ROW: begin
                // retire the low digit of the row sum, advance to next multiplier digit
                n_l = {sum[3:0], r_l[DW-1:4]};
                n_h = {4'd0, sum[NW-1:4]};
                n_b = {4'd0, r_b[DW-1:4]};
            end
            CMD_MUL_DONE:  n_status = (r_h != '0) ? ST_LOST : ST_OK;
            CMD_DIV_ZERO:  n_status = ST_DIVZ;
            CMD_DIV_SHIFT: begin
                n_h = {r_h[DW-1:0], r_a[DW-1 -: 4]};
                n_a = {r_a[DW-5:0], 4'd0};
                n_q = 4'd0;
            end
            CMD_DIV_TRY: begin
                if (o_stat.div_more) begin
                    n_h = sum;
                    n_q = r_q + 4'd1;
                end else begin
                    n_l = {r_l[DW-5:0], r_q};
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_a      <= n_a;
        r_b      <= n_b;
        r_h      <= n_h;
        r_l      <= n_l;
        r_q      <= n_q;
        r_order  <= n_order;
        r_status <= n_status;
        if (i_cmd.op == CMD_MUL_BUILD) begin
            r_mul[i_cmd.idx] <= sum;
        end
    end

    assign res_vec        = VW'(r_l);
    assign o_result_lower = res_vec[LOW_W-1:0];
    assign o_result_upper = res_vec[RAW_W-1:LOW_W];
    assign o_order        = r_order;
    assign o_status       = r_status;

endmodule

// ----- design/dba_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dba_ctrl: sequencer of the decimal BCD arithmetic unit
// Steps the datapath through each operation and hands the result over.
// ----------------------------------------------------------------------------
module dba_ctrl import dba_pkg::*; #(
    parameter int DIGITS = 30
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    input  logic       i_valid,
    input  logic [2:0] i_operation,
    input  logic       i_out_free,
    input  t_dp_stat   i_stat,
    output logic       o_busy,
    output logic       o_out_load,
    output t_dp_cmd    o_cmd
);

    localparam int CW = $clog2(DIGITS);

    t_state        r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state    = r_state;
        n_cnt      = r_cnt;
        o_cmd.op   = CMD_NONE;
        o_cmd.idx  = r_cnt[3:0];
        o_out_load = 1'b0;
        o_busy     = (r_state != S_IDLE);
        unique case (r_state)
            S_IDLE: begin
                if (i_valid) begin
                    o_cmd.op = CMD_LOAD;
                    n_cnt    = CW'(1);
                    case (i_operation)
                        OP_ADD:  n_state = S_ADD;
                        OP_SUB:  n_state = S_SUB;
                        OP_MUL:  n_state = S_MBUILD;
                        OP_DIV:  n_state = S_DCHK;
                        default: n_state = S_DONE;
                    endcase
                end
            end
            S_ADD: begin
                o_cmd.op = CMD_ADD;
                n_state  = S_DONE;
            end
            S_SUB: begin
                o_cmd.op = CMD_SUB;
                n_state  = S_DONE;
            end
            S_MBUILD: begin
                // one multiple of a per cycle, 1a through 9a
                o_cmd.op = CMD_MUL_BUILD;
                if (r_cnt == CW'(9)) begin
                    n_state = S_MCLR;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_MCLR: begin
                o_cmd.op = CMD_MUL_CLR;
                n_cnt    = '0;
                n_state  = S_MROW;
            end
            S_MROW: begin
                o_cmd.op = CMD_MUL_ROW;
                if (r_cnt == CW'(DIGITS - 1)) begin
                    n_state = S_MDONE;
                end else begin
                    n_cnt = r_cnt + CW'(1);
                end
            end
            S_MDONE: begin
                o_cmd.op = CMD_MUL_DONE;
                n_state  = S_DONE;
            end
            S_DCHK: begin
                if (i_stat.b_zero) begin
                    o_cmd.op = CMD_DIV_ZERO;
                    n_state  = S_DONE;
                end else begin
                    n_cnt   = CW'(DIGITS - 1);
                    n_state = S_DSHIFT;
                end
            end
            S_DSHIFT: begin
                o_cmd.op = CMD_DIV_SHIFT;
                n_state  = S_DTRY;
            end
            S_DTRY: begin
                o_cmd.op = CMD_DIV_TRY;
                if (!i_stat.div_more) begin
                    if (r_cnt == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_cnt   = r_cnt - CW'(1);
                        n_state = S_DSHIFT;
                    end
                end
            end
            S_DONE: begin
                // hold until the output register can take the result
                o_out_load = i_out_free;
                if (i_out_free) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

endmodule

// ----- design/decimal_bcd_arith_unit.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_bcd_arith_unit: unsigned packed-BCD add, subtract, multiply, divide
// Top level: sequencer, datapath and result output register.
// ----------------------------------------------------------------------------
// One item is worked on at a time; the input is stalled from acceptance until
// the result has moved into the output register, which then waits for its
// transfer while the next item runs. Codes other than add, subtract,
// multiply and divide only load the operands and report their order.
// Multiply builds the multiples 1a..9a in the shared BCD adder, then adds
// one product row per multiplier digit. Divide does, per quotient digit,
// one shift and q + 1 trial subtractions; a zero divisor ends with the
// divide-by-zero status. Nibbles above 9 read as 9.
// ----------------------------------------------------------------------------
module decimal_bcd_arith_unit import dba_pkg::*; #(
    parameter int DIGITS = 30
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_operation,
    input  logic [UP_W-1:0]   i_a_upper,
    input  logic [LOW_W-1:0]  i_a_lower,
    input  logic [UP_W-1:0]   i_b_upper,
    input  logic [LOW_W-1:0]  i_b_lower,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [UP_W-1:0]   o_result_upper,
    output logic [LOW_W-1:0]  o_result_lower,
    output logic [1:0]        o_order,
    output logic [1:0]        o_status
);

    t_dp_cmd          cmd;
    t_dp_stat         stat;
    logic             busy, out_load, out_free;
    logic [UP_W-1:0]  dp_upper;
    logic [LOW_W-1:0] dp_lower;
    logic [1:0]       dp_order, dp_status;

    logic             r_ovalid;
    logic [UP_W-1:0]  r_upper;
    logic [LOW_W-1:0] r_lower;
    logic [1:0]       r_order, r_status;

    assign out_free = !r_ovalid || !i_stall;

    dba_ctrl #(.DIGITS(DIGITS)) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .i_operation (i_operation),
        .i_out_free  (out_free),
        .i_stat      (stat),
        .o_busy      (busy),
        .o_out_load  (out_load),
        .o_cmd       (cmd)
    );

    dba_datapath #(.DIGITS(DIGITS)) u_dp (
        .i_clk          (i_clk),
        .i_cmd          (cmd),
        .i_a_upper      (i_a_upper),
        .i_a_lower      (i_a_lower),
        .i_b_upper      (i_b_upper),
        .i_b_lower      (i_b_lower),
        .o_stat         (stat),
        .o_result_upper (dp_upper),
        .o_result_lower (dp_lower),
        .o_order        (dp_order),
        .o_status       (dp_status)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (out_load) begin
            r_ovalid <= 1'b1;
        end else if (!i_stall) begin
            r_ovalid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_upper  <= dp_upper;
            r_lower  <= dp_lower;
            r_order  <= dp_order;
            r_status <= dp_status;
        end
    end

    assign o_stall        = busy;
    assign o_valid        = r_ovalid;
    assign o_result_upper = r_upper;
    assign o_result_lower = r_lower;
    assign o_order        = r_order;
    assign o_status       = r_status;

endmodule

// ----- design/dba_checker.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dba_checker: port-level checks of the decimal BCD arithmetic unit
// Watches the two channels and the result codes; bound to the top level.
// ----------------------------------------------------------------------------
module dba_checker import dba_pkg::*; (
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_valid,
    input logic              o_stall,
    input logic              o_valid,
    input logic              i_stall,
    input logic [UP_W-1:0]   o_result_upper,
    input logic [LOW_W-1:0]  o_result_lower,
    input logic [1:0]        o_order,
    input logic [1:0]        o_status
);

    // a held result does not change
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && i_stall |=> o_valid && $stable(o_result_upper)
            && $stable(o_result_lower) && $stable(o_status))
        else $error("result changed while stalled");

    // one item in flight: stall right after an input transfer
    a_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && !o_stall |=> o_stall)
        else $error("input not stalled after transfer");

    a_divz_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_DIVZ |-> o_result_upper == '0 && o_result_lower == '0)
        else $error("divide by zero gave nonzero result");

    a_neg_less: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_status == ST_NEG |->
            o_order == ORD_LESS && o_result_upper == '0 && o_result_lower == '0)
        else $error("clamped difference without a less than b");

endmodule

bind decimal_bcd_arith_unit dba_checker u_dba_checker (
    .i_clk          (i_clk),
    .i_rst_n        (i_rst_n),
    .i_valid        (i_valid),
    .o_stall        (o_stall),
    .o_valid        (o_valid),
    .i_stall        (i_stall),
    .o_result_upper (o_result_upper),
    .o_result_lower (o_result_lower),
    .o_order        (o_order),
    .o_status       (o_status)
);

// ----- verif/decimal_bcd_arith_unit_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// decimal_bcd_arith_unit_tb: self-checking bench for the packed-BCD unit
// Drives add, subtract, multiply, divide, compare and unused codes through the
// valid/stall input, predicts each result digit by digit and checks every
// output transfer against the oldest prediction, under several idling phases.
// ----------------------------------------------------------------------------
module decimal_bcd_arith_unit_tb;
    import dba_pkg::*;

    localparam int NDIG = 30;
    localparam logic [2:0] OP_CMP = 3'd4;
    localparam int LIMIT_CYCLES = 1500000;

    typedef struct packed {
        logic [2:0]       op;
        logic [UP_W-1:0]  au;
        logic [LOW_W-1:0] al;
        logic [UP_W-1:0]  bu;
        logic [LOW_W-1:0] bl;
    } t_item;

    typedef struct packed {
        logic [UP_W-1:0]  ru;
        logic [LOW_W-1:0] rl;
        logic [1:0]       ord;
        logic [1:0]       st;
    } t_res;

    typedef int unsigned t_digits [NDIG+1];

    logic i_clk, i_rst_n;
    logic i_valid, o_stall, o_valid, i_stall;
    logic [2:0] i_operation;
    logic [UP_W-1:0] i_a_upper, i_b_upper, o_result_upper;
    logic [LOW_W-1:0] i_a_lower, i_b_lower, o_result_lower;
    logic [1:0] o_order, o_status;

    t_item pending_items[$];
    t_res  expected_results[$];
    int    errors = 0;
    int    checked = 0;
    int    cycle = 0;
    int    send_idle_pct = 0;
    int    recv_stall_pct = 0;
    bit    stimulus_done = 0;
    int    op_seen[8];

    decimal_bcd_arith_unit uut (.*);

    initial begin
        i_clk = 0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic t_digits unpack_bcd(logic [UP_W-1:0] u, logic [LOW_W-1:0] l);
        t_digits d;
        logic [RAW_W-1:0] raw;
        logic [3:0] nib;
        raw = {u, l};
        for (int k = 0; k <= NDIG; k++) d[k] = 0;
        for (int k = 0; k < NDIG; k++) begin
            nib = raw[4*k +: 4];
            d[k] = (nib > 9) ? 9 : nib;
        end
        return d;
    endfunction

    function automatic int cmp_bcd(t_digits x, t_digits y, int n);
        for (int k = n - 1; k >= 0; k--) begin
            if (x[k] < y[k]) return -1;
            if (x[k] > y[k]) return 1;
        end
        return 0;
    endfunction

    function automatic t_digits sub_bcd(t_digits x, t_digits y, int n);
        int unsigned borrow, t;
        borrow = 0;
        for (int k = 0; k < n; k++) begin
            t = y[k] + borrow;
            if (x[k] < t) begin
                x[k] = x[k] + 10 - t;
                borrow = 1;
            end else begin
                x[k] = x[k] - t;
                borrow = 0;
            end
        end
        return x;
    endfunction

    function automatic t_res bcd_arith(t_item it);
        t_res res;
        t_digits a, b, r, rem;
        int unsigned prod[2*NDIG];
        int unsigned carry, s, q;
        int c;
        logic [RAW_W-1:0] raw;
        bit zero;
        a = unpack_bcd(it.au, it.al);
        b = unpack_bcd(it.bu, it.bl);
        for (int k = 0; k <= NDIG; k++) r[k] = 0;
        res.st = ST_OK;
        c = cmp_bcd(a, b, NDIG);
        res.ord = (c == 0) ? ORD_EQ : ((c < 0) ? ORD_LESS : ORD_GT);
        case (it.op)
            OP_ADD: begin
                carry = 0;
                for (int k = 0; k < NDIG; k++) begin
                    s = a[k] + b[k] + carry;
                    r[k] = s % 10;
                    carry = s / 10;
                end
                if (carry != 0) res.st = ST_LOST;
            end
            OP_SUB: begin
                if (c < 0) res.st = ST_NEG;
                else r = sub_bcd(a, b, NDIG);
            end
            OP_MUL: begin
                for (int k = 0; k < 2*NDIG; k++) prod[k] = 0;
                for (int i = 0; i < NDIG; i++)
                    for (int j = 0; j < NDIG; j++) prod[i+j] += a[i] * b[j];
                carry = 0;
                for (int k = 0; k < 2*NDIG; k++) begin
                    s = prod[k] + carry;
                    prod[k] = s % 10;
                    carry = s / 10;
                end
                for (int k = 0; k < NDIG; k++) r[k] = prod[k];
                for (int k = NDIG; k < 2*NDIG; k++) if (prod[k] != 0) res.st = ST_LOST;
                if (carry != 0) res.st = ST_LOST;
            end
            OP_DIV: begin
                zero = 1;
                for (int k = 0; k < NDIG; k++) if (b[k] != 0) zero = 0;
                if (zero) res.st = ST_DIVZ;
                else begin
                    for (int k = 0; k <= NDIG; k++) rem[k] = 0;
                    for (int i = NDIG - 1; i >= 0; i--) begin
                        for (int k = NDIG; k > 0; k--) rem[k] = rem[k-1];
                        rem[0] = a[i];
                        q = 0;
                        while (q < 9 && cmp_bcd(rem, b, NDIG + 1) >= 0) begin
                            rem = sub_bcd(rem, b, NDIG + 1);
                            q++;
                        end
                        r[i] = q;
                    end
                end
            end
            default: ;
        endcase
        raw = '0;
        for (int k = 0; k < NDIG; k++) raw[4*k +: 4] = r[k][3:0];
        {res.ru, res.rl} = raw;
        return res;
    endfunction

    // Random operand with a random count of significant digits; some bad nibbles.
    function automatic logic [RAW_W-1:0] rand_operand();
        logic [RAW_W-1:0] raw;
        int len;
        raw = '0;
        len = $urandom_range(0, NDIG);
        if ($urandom_range(0, 9) == 0) len = NDIG;
        for (int k = 0; k < len; k++) begin
            if ($urandom_range(0, 19) == 0) raw[4*k +: 4] = 4'($urandom_range(10, 15));
            else raw[4*k +: 4] = 4'($urandom_range(0, 9));
        end
        return raw;
    endfunction

    task automatic add_item(logic [2:0] op, logic [RAW_W-1:0] a, logic [RAW_W-1:0] b);
        t_item it;
        it.op = op;
        {it.au, it.al} = a;
        {it.bu, it.bl} = b;
        pending_items.push_back(it);
    endtask

    // Driver: present the queue head, advance on each accepted transfer.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && !o_stall) begin
                expected_results.push_back(bcd_arith(pending_items[0]));
                op_seen[pending_items[0].op]++;
                void'(pending_items.pop_front());
            end
            if ((!i_valid || !o_stall) && (pending_items.size() > 0)
                    && ($urandom_range(0, 99) >= send_idle_pct)) begin
                t_item nx;
                nx = pending_items[0];
                i_valid     <= 1'b1;
                i_operation <= nx.op;
                i_a_upper   <= nx.au;
                i_a_lower   <= nx.al;
                i_b_upper   <= nx.bu;
                i_b_lower   <= nx.bl;
            end else if (!i_valid || !o_stall) begin
                i_valid <= 1'b0;
            end
        end
    end

    // Monitor: check each output transfer, then pick the next stall value.
    always @(posedge i_clk) begin
        cycle <= cycle + 1;
        if (i_rst_n) begin
            if (o_valid && !i_stall) begin
                if (expected_results.size() == 0) begin
                    $error("unexpected result transfer");
                    errors++;
                end else begin
                    t_res e;
                    e = expected_results.pop_front();
                    checked++;
                    if (o_result_upper !== e.ru) begin
                        $error("result_upper exp %h got %h", e.ru, o_result_upper);
                        errors++;
                    end
                    if (o_result_lower !== e.rl) begin
                        $error("result_lower exp %h got %h", e.rl, o_result_lower);
                        errors++;
                    end
                    if (o_order !== e.ord) begin
                        $error("order exp %0d got %0d", e.ord, o_order);
                        errors++;
                    end
                    if (o_status !== e.st) begin
                        $error("status exp %0d got %0d", e.st, o_status);
                        errors++;
                    end
                end
            end
            i_stall <= ($urandom_range(0, 99) < recv_stall_pct);
        end
    end

    initial begin
        logic [RAW_W-1:0] nines, one, big;
        nines = '0;
        one = 1;
        for (int k = 0; k < NDIG; k++) nines[4*k +: 4] = 4'd9;
        big = '1;
        i_rst_n = 0; i_valid = 0; i_stall = 0;
        i_operation = '0; i_a_upper = '0; i_a_lower = '0; i_b_upper = '0; i_b_lower = '0;
        // Directed: extremes, each operation, lost carry, negative, zero divisor,
        // invalid nibbles, unused codes.
        add_item(OP_ADD, '0, '0);
        add_item(OP_ADD, nines, one);
        add_item(OP_ADD, big, big);
        add_item(OP_SUB, one, nines);
        add_item(OP_SUB, nines, nines);
        add_item(OP_SUB, big, one);
        add_item(OP_MUL, nines, nines);
        add_item(OP_MUL, big, '0);
        add_item(OP_MUL, 120'h12345, 120'h6789);
        add_item(OP_DIV, nines, '0);
        add_item(OP_DIV, nines, one);
        add_item(OP_DIV, nines, 120'h7);
        add_item(OP_DIV, one, nines);
        add_item(OP_DIV, big, 120'hF);
        add_item(OP_CMP, one, one);
        add_item(OP_CMP, '0, big);
        add_item(OP_CMP, big, '0);
        for (int op = 5; op < 8; op++) add_item(op[2:0], nines, one);
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1;
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 47 : (ph == 3) ? 23 : 0;
            recv_stall_pct = (ph == 2) ? 47 : (ph == 3) ? 23 : 0;
            repeat (132) begin
                logic [2:0] op;
                logic [RAW_W-1:0] a, b;
                op = ($urandom_range(0, 19) == 0) ? 3'($urandom_range(5, 7))
                                                  : 3'($urandom_range(0, 4));
                a = rand_operand();
                b = ($urandom_range(0, 9) == 0) ? a : rand_operand();
                add_item(op, a, b);
            end
            while (pending_items.size() != 0 || expected_results.size() != 0)
                @(posedge i_clk);
        end
        stimulus_done = 1;
        repeat (20) @(posedge i_clk);
        $display("checked %0d results: add %0d sub %0d mul %0d div %0d cmp %0d other %0d",
                 checked, op_seen[0], op_seen[1], op_seen[2], op_seen[3], op_seen[4],
                 op_seen[5] + op_seen[6] + op_seen[7]);
        if (errors == 0 && expected_results.size() == 0) begin
            $display("decimal_bcd_arith_unit_tb passed");
        end else begin
            $display("decimal_bcd_arith_unit_tb failed");
        end
        $finish;
    end

    initial begin
        wait (cycle >= LIMIT_CYCLES);
        $display("timeout after %0d cycles", cycle);
        $display("decimal_bcd_arith_unit_tb failed");
        $finish;
    end

endmodule
